// ===== hdl/mlfd_pkg.sv =====
package mlfd_pkg;

  localparam int FRAME_BYTES = 14;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [13:0] magnitude;
    logic        is_negative;
    logic [2:0]  decimal_shift;
    logic        value_valid;
    logic        overload;
    logic [2:0]  unit_prefix;
    logic [2:0]  unit_base;
    logic        unit_valid;
    logic [7:0]  annunciators;
  } out_item_t;

  typedef logic [3:0] digit_t;

  localparam digit_t DIG_BLANK = 4'd10;
  localparam digit_t DIG_L     = 4'd11;

  localparam logic [6:0] SEG_0 = 7'h7D;
  localparam logic [6:0] SEG_1 = 7'h05;
  localparam logic [6:0] SEG_2 = 7'h5B;
  localparam logic [6:0] SEG_3 = 7'h1F;
  localparam logic [6:0] SEG_4 = 7'h27;
  localparam logic [6:0] SEG_5 = 7'h3E;
  localparam logic [6:0] SEG_6 = 7'h7E;
  localparam logic [6:0] SEG_7 = 7'h15;
  localparam logic [6:0] SEG_8 = 7'h7F;
  localparam logic [6:0] SEG_9 = 7'h3F;
  localparam logic [6:0] SEG_L = 7'h68;

  localparam logic [2:0] PFX_NONE  = 3'd0;
  localparam logic [2:0] PFX_NANO  = 3'd1;
  localparam logic [2:0] PFX_MICRO = 3'd2;
  localparam logic [2:0] PFX_MILLI = 3'd3;
  localparam logic [2:0] PFX_KILO  = 3'd4;
  localparam logic [2:0] PFX_MEGA  = 3'd5;

  localparam logic [2:0] BASE_VOLT    = 3'd0;
  localparam logic [2:0] BASE_AMPERE  = 3'd1;
  localparam logic [2:0] BASE_OHM     = 3'd2;
  localparam logic [2:0] BASE_FARAD   = 3'd3;
  localparam logic [2:0] BASE_HERTZ   = 3'd4;
  localparam logic [2:0] BASE_PERCENT = 3'd5;
  localparam logic [2:0] BASE_CELSIUS = 3'd6;

  function automatic digit_t seg_to_digit(input logic [6:0] code);
    digit_t d;
    case (code)
      SEG_0:   d = 4'd0;
      SEG_1:   d = 4'd1;
      SEG_2:   d = 4'd2;
      SEG_3:   d = 4'd3;
      SEG_4:   d = 4'd4;
      SEG_5:   d = 4'd5;
      SEG_6:   d = 4'd6;
      SEG_7:   d = 4'd7;
      SEG_8:   d = 4'd8;
      SEG_9:   d = 4'd9;
      SEG_L:   d = DIG_L;
      default: d = DIG_BLANK;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/mlfd_front.sv =====
module mlfd_front
  import mlfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  output logic     job_push,
  output frame_t   job
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] wr_idx;
  logic             last;
  logic [7:0]       store [FRAME_BYTES];

  always_comb begin
    if (item.frame_start || (pos >= POS_W'(FRAME_BYTES))) begin
      wr_idx = '0;
    end else begin
      wr_idx = pos;
    end
    last     = (wr_idx == POS_W'(FRAME_BYTES - 1));
    job_push = accept && last;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      job[i] = store[i];
    end
    job[FRAME_BYTES-1] = item.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= last ? '0 : POS_W'(wr_idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store[wr_idx] <= item.data_byte;
    end
  end

endmodule

// ===== hdl/mlfd_queue.sv =====
module mlfd_queue
  import mlfd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  frame_t wr_data,
  input  logic   rd,
  output frame_t rd_data,
  output logic   q_full,
  output logic   q_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (wr && !rd) begin
        count <= CNT_W'(count + 1'b1);
      end else if (rd && !wr) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full && !rd |-> !wr)
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !rd)
    else $error("frame queue read while empty");

endmodule

// ===== hdl/mlfd_back.sv =====
module mlfd_back
  import mlfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  frame_t    frame,
  input  logic      job_ready,
  output logic      job_take,
  input  logic      pop,
  output logic      out_valid,
  output out_item_t result
);

  out_item_t dec;
  digit_t    d [4];
  logic      all_num;
  logic      any_l;

  always_comb begin
    all_num = 1'b1;
    any_l   = 1'b0;
    for (int k = 0; k < 4; k++) begin
      d[k] = seg_to_digit({frame[2*k+1][2:0], frame[2*k+2][3:0]});
      if (d[k] > 4'd9) begin
        all_num = 1'b0;
      end
      if (d[k] == DIG_L) begin
        any_l = 1'b1;
      end
    end

    dec.value_valid = all_num;
    dec.overload    = any_l;
    if (all_num) begin
      dec.magnitude = 14'(d[0] * 14'd1000) + 14'(d[1] * 14'd100)
                    + 14'(d[2] * 14'd10) + 14'(d[3]);
    end else begin
      dec.magnitude = '0;
    end

    dec.is_negative   = frame[1][3];
    dec.decimal_shift = 3'(frame[7][3]) + 3'({frame[5][3], 1'b0})
                      + (frame[3][3] ? 3'd3 : 3'd0);

    dec.unit_valid = 1'b1;
    if (frame[13][2]) begin
      dec.unit_prefix = PFX_MILLI;
      dec.unit_base   = BASE_VOLT;
    end else begin
      if (frame[9][1])       dec.unit_prefix = PFX_KILO;
      else if (frame[9][2])  dec.unit_prefix = PFX_NANO;
      else if (frame[9][3])  dec.unit_prefix = PFX_MICRO;
      else if (frame[10][1]) dec.unit_prefix = PFX_MEGA;
      else if (frame[10][3]) dec.unit_prefix = PFX_MILLI;
      else                   dec.unit_prefix = PFX_NONE;

      if (frame[10][2])      dec.unit_base = BASE_PERCENT;
      else if (frame[11][2]) dec.unit_base = BASE_OHM;
      else if (frame[11][3]) dec.unit_base = BASE_FARAD;
      else if (frame[12][1]) dec.unit_base = BASE_HERTZ;
      else if (frame[12][2]) dec.unit_base = BASE_VOLT;
      else if (frame[12][3]) dec.unit_base = BASE_AMPERE;
      else if (frame[13][1]) dec.unit_base = BASE_CELSIUS;
      else begin
        dec.unit_base  = BASE_VOLT;
        dec.unit_valid = 1'b0;
      end
    end

    dec.annunciators = {frame[12][0], frame[9][0], frame[10][0], frame[11][1],
                        frame[11][0], frame[0][3], frame[0][2], frame[0][1]};
  end

  assign job_take = job_ready && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (job_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      result <= dec;
    end
  end

  a_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(result))
    else $error("pending reading lost or changed");

  a_valid_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(result.value_valid && result.overload))
    else $error("valid reading flagged as overload");

  a_mag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.value_valid |-> result.magnitude == '0)
    else $error("invalid reading carries a magnitude");

  a_no_base: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.unit_valid |-> result.unit_base == BASE_VOLT)
    else $error("unit base set without unit flag");

endmodule

// ===== hdl/multimeter_lcd_frame_decoder_unit.sv =====
// A reading goes from the last frame byte into the frame queue, which is written when that byte is transferred,
// and is then decoded into the output register once that register is empty or its reading is popped.
// Throughput: one byte per cycle while full is low; one reading per 14-byte frame.
// full rises only when the frame queue is full behind a stalled result.
// Reset clears the byte position, the frame queue and the result valid flag;
// the frame byte store is not cleared.
module multimeter_lcd_frame_decoder_unit
  import mlfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic   accept;
  logic   job_push;
  frame_t job;
  frame_t head;
  logic   q_full;
  logic   q_empty;
  logic   job_take;
  logic   out_valid;

  assign full   = q_full;
  assign accept = push && !full;
  assign empty  = !out_valid;

  mlfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job)
  );

  mlfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_data (job),
    .rd      (job_take),
    .rd_data (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  mlfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .frame     (head),
    .job_ready (!q_empty),
    .job_take  (job_take),
    .pop       (pop),
    .out_valid (out_valid),
    .result    (result)
  );

endmodule

// ===== test/mlfd_reading_check.sv =====
module mlfd_reading_check
  import mlfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  item,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t result,
  output int        failures,
  output int        pending
);

  frame_t    collected;
  int        next_pos;
  int        mismatches = 0;
  out_item_t readings_due[$];

  assign failures = mismatches;

  function automatic digit_t lcd_digit(input logic [6:0] code);
    logic [6:0] glyphs [10];
    digit_t     d;
    int         i;
    glyphs = '{SEG_0, SEG_1, SEG_2, SEG_3, SEG_4, SEG_5, SEG_6, SEG_7, SEG_8, SEG_9};
    d = (code == SEG_L) ? DIG_L : DIG_BLANK;
    for (i = 0; i < 10; i++) begin
      if (glyphs[i] == code) d = digit_t'(i);
    end
    return d;
  endfunction

  function automatic out_item_t decode_reading(input frame_t f);
    out_item_t   r;
    digit_t      d;
    logic [13:0] mag;
    int          k;
    r = '0;
    r.value_valid = 1'b1;
    r.unit_valid = 1'b1;
    mag = '0;
    for (k = 0; k < 4; k++) begin
      d = lcd_digit({f[2*k+1][2:0], f[2*k+2][3:0]});
      if (d > 4'd9) begin
        r.value_valid = 1'b0;
        if (d == DIG_L) r.overload = 1'b1;
      end else begin
        mag = 14'(mag * 10 + d);
      end
    end
    r.magnitude = r.value_valid ? mag : '0;
    r.is_negative = f[1][3];
    r.decimal_shift = {2'b00, f[7][3]} + (f[5][3] ? 3'd2 : 3'd0) + (f[3][3] ? 3'd3 : 3'd0);
    if (f[13][2]) begin
      // millivolt overrides the prefix and base flags
      r.unit_prefix = PFX_MILLI;
      r.unit_base = BASE_VOLT;
    end else begin
      if (f[9][1])       r.unit_prefix = PFX_KILO;
      else if (f[9][2])  r.unit_prefix = PFX_NANO;
      else if (f[9][3])  r.unit_prefix = PFX_MICRO;
      else if (f[10][1]) r.unit_prefix = PFX_MEGA;
      else if (f[10][3]) r.unit_prefix = PFX_MILLI;
      else               r.unit_prefix = PFX_NONE;
      if (f[10][2])      r.unit_base = BASE_PERCENT;
      else if (f[11][2]) r.unit_base = BASE_OHM;
      else if (f[11][3]) r.unit_base = BASE_FARAD;
      else if (f[12][1]) r.unit_base = BASE_HERTZ;
      else if (f[12][2]) r.unit_base = BASE_VOLT;
      else if (f[12][3]) r.unit_base = BASE_AMPERE;
      else if (f[13][1]) r.unit_base = BASE_CELSIUS;
      else begin
        r.unit_base = BASE_VOLT;
        r.unit_valid = 1'b0;
      end
    end
    r.annunciators = {f[12][0], f[9][0], f[10][0], f[11][1], f[11][0],
                      f[0][3], f[0][2], f[0][1]};
    return r;
  endfunction

  task automatic check_field(input string field, input logic [13:0] want,
                             input logic [13:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  task automatic compare_reading(input out_item_t want, input out_item_t got);
    check_field("magnitude", want.magnitude, got.magnitude);
    check_field("is_negative", want.is_negative, got.is_negative);
    check_field("decimal_shift", want.decimal_shift, got.decimal_shift);
    check_field("value_valid", want.value_valid, got.value_valid);
    check_field("overload", want.overload, got.overload);
    check_field("unit_prefix", want.unit_prefix, got.unit_prefix);
    check_field("unit_base", want.unit_base, got.unit_base);
    check_field("unit_valid", want.unit_valid, got.unit_valid);
    check_field("annunciators", want.annunciators, got.annunciators);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      next_pos = 0;
      readings_due.delete();
    end else begin
      if (pop && !empty) begin
        if (readings_due.size() == 0) begin
          mismatches++;
          $display("%0t: reading expected none, got %p", $time, result);
        end else begin
          compare_reading(readings_due.pop_front(), result);
        end
      end
      if (push && !full) begin
        if (item.frame_start) next_pos = 0;
        collected[next_pos] = item.data_byte;
        next_pos++;
        if (next_pos == FRAME_BYTES) begin
          readings_due.push_back(decode_reading(collected));
          next_pos = 0;
        end
      end
    end
    pending <= readings_due.size();
  end

endmodule

// ===== test/multimeter_lcd_frame_decoder_unit_tb.sv =====
module multimeter_lcd_frame_decoder_unit_tb;
  import mlfd_pkg::*;

  localparam int BYTE_TARGET = 1350;
  localparam int CALM_TAIL   = 150;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 250;
  localparam int PAUSE_AT    = 700;
  localparam int STALL_LIMIT = 3000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  item = '0;
  logic      full;
  logic      empty;
  out_item_t result;
  int        failures;
  int        pending;

  int bytes_sent = 0;
  int quiet = 0;
  bit jitter = 1'b0;
  bit holding = 1'b0;
  bit held = 1'b0;
  bit paused = 1'b0;

  always #5 clk = ~clk;

  multimeter_lcd_frame_decoder_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  mlfd_reading_check reading_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .failures(failures), .pending(pending)
  );

  task automatic send_byte(input logic [7:0] b, input logic s);
    if (jitter && !holding && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{data_byte: b, frame_start: s};
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  function automatic logic [6:0] random_glyph();
    logic [6:0] glyphs [10];
    int         pick;
    glyphs = '{SEG_0, SEG_1, SEG_2, SEG_3, SEG_4, SEG_5, SEG_6, SEG_7, SEG_8, SEG_9};
    pick = $urandom_range(0, 15);
    if (pick < 12) return glyphs[pick % 10];
    if (pick == 12) return SEG_L;
    if (pick == 13) return 7'h00;
    return 7'($urandom);
  endfunction

  task automatic send_frame(input logic start, input int len);
    frame_t     f;
    logic [6:0] glyph;
    int         i;
    for (i = 0; i < FRAME_BYTES; i++) f[i] = 8'($urandom);
    for (i = 0; i < 4; i++) begin
      glyph = random_glyph();
      f[2*i+1][2:0] = glyph[6:4];
      f[2*i+2][3:0] = glyph[3:0];
    end
    // sparse unit flags so every priority level gets hit
    for (i = 9; i < FRAME_BYTES; i++) f[i] = 8'($urandom & $urandom);
    for (i = 0; i < len; i++) send_byte(f[i], (i == 0) ? start : 1'b0);
  endtask

  // result side
  initial begin
    forever begin
      if (!held && bytes_sent >= HOLD_AT) begin
        held = 1'b1;
        holding = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else if (jitter && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("multimeter_lcd_frame_decoder_unit_tb: errors");
    $finish;
  end

  initial begin
    int i;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray bytes, a restart with every bit set, then a frame begun without start
    for (i = 0; i < 3; i++) send_byte(8'h00, 1'b0);
    for (i = 0; i < FRAME_BYTES; i++) send_byte(8'hFF, i == 0);
    for (i = 0; i < 8; i++) send_byte(8'h00, 1'b0);

    while (bytes_sent < BYTE_TARGET) begin
      jitter = (bytes_sent < BYTE_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      if (!paused && bytes_sent >= PAUSE_AT) begin
        paused = 1'b1;
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      case ($urandom_range(0, 9))
        0:       send_frame(1'b1, $urandom_range(1, FRAME_BYTES - 1));
        1:       repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        2:       send_frame(1'b0, FRAME_BYTES);
        default: send_frame(1'b1, FRAME_BYTES);
      endcase
    end

    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("multimeter_lcd_frame_decoder_unit_tb: clean");
    end else begin
      $display("multimeter_lcd_frame_decoder_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mlfd_pkg.sv
hdl/mlfd_front.sv
hdl/mlfd_queue.sv
hdl/mlfd_back.sv
hdl/multimeter_lcd_frame_decoder_unit.sv
test/mlfd_reading_check.sv
test/multimeter_lcd_frame_decoder_unit_tb.sv
